### hw/rtl/l2kg_pkg.sv
// Package for the Lanczos-2 kernel generator: sizes, fixed-point constants,
// sequencer states, divider request and response types and helper functions.
// Depends on nothing.
package l2kg_pkg;

    localparam int TAP_SLOTS     = 16;
    localparam int MAX_SAMPLES   = 29;
    localparam int CNT_W         = $clog2(TAP_SLOTS + 1);
    localparam int IDX_W         = $clog2(TAP_SLOTS);
    localparam int RATIO_W       = 24;
    localparam int LEN_W         = 14;
    localparam int WEIGHT_W      = 18;
    localparam int OFF_W         = 24;
    localparam int TAPO_W        = 4;
    localparam int RAW_W         = 33;
    localparam int SUM_W         = 40;
    localparam int ACC_W         = 40;
    localparam int Q_W           = 48;
    localparam int DSR_W         = 36;
    localparam int STEP_W        = 6;
    localparam int TERM_W        = 4;
    localparam int SERIES_TERMS  = 12;
    localparam int OFF_DVD_W     = CNT_W + 20;

    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
    localparam logic [31:0] PI_Q28  = 32'd843314857;

    localparam logic [STEP_W-1:0] U_STEPS      = STEP_W'(28);
    localparam logic [STEP_W-1:0] SERIES_STEPS = STEP_W'(36);
    localparam logic [STEP_W-1:0] NORM_STEPS   = STEP_W'(Q_W);
    localparam logic [STEP_W-1:0] OFF_STEPS    = STEP_W'(OFF_DVD_W);

    typedef enum logic [4:0] {
        S_IDLE,
        S_TAP,
        S_UDIV,
        S_VMUL,
        S_V2MUL,
        S_TSTART,
        S_TMUL,
        S_TDIV0,
        S_TDIV,
        S_TEND,
        S_SQ,
        S_LMUL,
        S_LFIN,
        S_NSTART,
        S_NDIV,
        S_OSTART,
        S_ODIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DSR_W-1:0]  rem0;
        logic [Q_W-1:0]    dividend;
        logic [DSR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [CNT_W-1:0] calc_kernel_size(input logic [RATIO_W-1:0] ratio);
        logic [RATIO_W+1:0] c2;
        logic [RATIO_W-15:0] c;
        logic [11:0] n;
        logic [11:0] ks;
        c2 = {1'b0, ratio, 1'b0} + (RATIO_W + 2)'(65535);
        c  = c2[RATIO_W+1:16];
        if (c < 10'd2) begin
            n = 12'd3;
        end else begin
            n = {1'b0, c, 1'b0} - 12'd1;
        end
        if (n < 12'd3) begin
            n = 12'd3;
        end
        if (n > 12'(MAX_SAMPLES)) begin
            n = 12'(MAX_SAMPLES);
        end
        ks = (n >> 1) + 12'd1;
        if (ks > 12'(TAP_SLOTS)) begin
            ks = 12'(TAP_SLOTS);
        end
        return ks[CNT_W-1:0];
    endfunction

    function automatic logic [9:0] series_divisor(input logic [TERM_W-1:0] k,
                                                  input logic cos_form);
        logic [19:0] two_k;
        logic [19:0] p;
        two_k = {15'b0, k, 1'b0};
        if (cos_form) begin
            p = (two_k - 20'd1) * two_k;
        end else begin
            p = two_k * (two_k + 20'd1);
        end
        return p[9:0];
    endfunction

endpackage

### hw/rtl/l2kg_div.sv
// Shared restoring divider, one quotient bit per cycle over a programmable count.
// Depends on l2kg_pkg for the request and response types.
module l2kg_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  l2kg_pkg::t_div_req   i_req,
    output l2kg_pkg::t_div_rsp   o_rsp
);
    import l2kg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [Q_W-1:0]    r_dvd;
    logic [Q_W-1:0]    r_quo;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              take;

    always_comb begin
        trial = {r_rem, r_dvd[Q_W-1]};
        diff  = trial - {1'b0, r_dsr};
        take  = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            r_dvd <= {r_dvd[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], take};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### hw/rtl/lanczos2_kernel_generator_top.sv
// Top level of the Lanczos-2 kernel generator: sequencer, shared multiplier and tap store.
// Depends on l2kg_pkg and l2kg_div.
//
//   channel   direction   handshake                  payload
//   request   in          i_in_valid / o_in_ready    i_scale_ratio, i_tex_length, i_vertical
//   tap       out         o_out_valid / i_out_ready  o_tap_index, o_weight, o_offset_x,
//                                                    o_offset_y, o_kernel_size, o_last_tap
//
// A request is taken only when the block is idle and yields sixteen tap items.
// Each nonzero tap is dominated by the divider, which yields one quotient bit per
// cycle over 24 series terms; normalisation and offsets follow for each item.
// Reset is synchronous and returns the sequencer to idle; a stalled output simply holds.
module lanczos2_kernel_generator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [l2kg_pkg::RATIO_W-1:0]         i_scale_ratio,
    input  logic [l2kg_pkg::LEN_W-1:0]           i_tex_length,
    input  logic                                 i_vertical,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [l2kg_pkg::TAPO_W-1:0]          o_tap_index,
    output logic signed [l2kg_pkg::WEIGHT_W-1:0] o_weight,
    output logic [l2kg_pkg::OFF_W-1:0]           o_offset_x,
    output logic [l2kg_pkg::OFF_W-1:0]           o_offset_y,
    output logic [l2kg_pkg::TAPO_W-1:0]          o_kernel_size,
    output logic                                 o_last_tap
);
    import l2kg_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [RATIO_W-1:0]         r_ratio;
    logic [LEN_W-1:0]           r_len;
    logic                       r_vert;
    logic [CNT_W-1:0]           r_ks;
    logic [CNT_W-1:0]           r_i;
    logic [27:0]                r_u;
    logic [31:0]                r_v2;
    logic [31:0]                r_mag;
    logic signed [ACC_W-1:0]    r_acc;
    logic [TERM_W-1:0]          r_k;
    logic                       r_cos;
    logic signed [ACC_W-1:0]    r_sn;
    logic signed [ACC_W-1:0]    r_cs;
    logic signed [SUM_W-1:0]    r_sum;
    logic [63:0]                r_prod;
    logic signed [RAW_W-1:0]    r_raw [TAP_SLOTS];
    logic [TAPO_W-1:0]          r_tap;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic [OFF_W-1:0]           r_off_x;
    logic [OFF_W-1:0]           r_off_y;
    logic [TAPO_W-1:0]          r_ks_out;
    logic                       r_last;

    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic signed [RAW_W-1:0] raw_rd;
    logic [RAW_W-1:0]        raw_abs;
    logic signed [ACC_W-1:0] sn_abs;
    logic signed [ACC_W-1:0] cs_abs;
    logic                    tap_skip;
    logic [LEN_W-1:0]        len_eff;
    logic [31:0]             term;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [RAW_W-1:0] raw_new;
    logic [Q_W-1:0]          quo;
    logic signed [WEIGHT_W-1:0] w_new;
    logic [OFF_W-1:0]        off_new;

    l2kg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        quo      = div_rsp.quotient;
        raw_rd   = r_raw[r_i[IDX_W-1:0]];
        raw_abs  = raw_rd[RAW_W-1] ? RAW_W'(-raw_rd) : RAW_W'(raw_rd);
        sn_abs   = r_sn[ACC_W-1] ? -r_sn : r_sn;
        cs_abs   = r_cs[ACC_W-1] ? -r_cs : r_cs;
        tap_skip = (r_i >= r_ks) || (32'({r_i, 15'b0}) >= 32'(r_ratio));
        len_eff  = (r_len == '0) ? LEN_W'(1) : r_len;
        term     = quo[31:0];
        acc_next = r_k[0] ? (r_acc - ACC_W'(term)) : (r_acc + ACC_W'(term));
        raw_new  = r_cs[ACC_W-1] ? -RAW_W'(r_prod[59:28]) : RAW_W'(r_prod[59:28]);
        if (raw_rd[RAW_W-1]) begin
            w_new = (quo >= Q_W'(131072)) ? WEIGHT_W'(18'h20000) : WEIGHT_W'(-quo[WEIGHT_W-1:0]);
        end else begin
            w_new = (quo > Q_W'(131071)) ? WEIGHT_W'(18'h1FFFF) : WEIGHT_W'(quo[WEIGHT_W-1:0]);
        end
        off_new = (quo > Q_W'(24'hFFFFFF)) ? OFF_W'(24'hFFFFFF) : quo[OFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                if (r_i == CNT_W'(TAP_SLOTS)) begin
                    n_state = S_NSTART;
                end else if (!tap_skip) begin
                    div_req.start    = 1'b1;
                    div_req.steps    = U_STEPS;
                    div_req.rem0     = DSR_W'({r_i, 15'b0});
                    div_req.dividend = '0;
                    div_req.divisor  = DSR_W'(r_ratio);
                    n_state = S_UDIV;
                end
            end
            S_UDIV: begin
                if (div_rsp.done) begin
                    n_state = S_VMUL;
                end
            end
            S_VMUL: begin
                mul_a   = {4'b0, r_u};
                mul_b   = PI_Q28;
                n_state = S_V2MUL;
            end
            S_V2MUL: begin
                mul_a   = {2'b0, r_prod[57:28]};
                mul_b   = {2'b0, r_prod[57:28]};
                n_state = S_TSTART;
            end
            S_TSTART: begin
                n_state = S_TMUL;
            end
            S_TMUL: begin
                mul_a   = r_mag;
                mul_b   = r_v2;
                n_state = S_TDIV0;
            end
            S_TDIV0: begin
                div_req.start    = 1'b1;
                div_req.steps    = SERIES_STEPS;
                div_req.rem0     = '0;
                div_req.dividend = {r_prod[63:28], 12'b0};
                div_req.divisor  = DSR_W'(series_divisor(r_k, r_cos));
                n_state = S_TDIV;
            end
            S_TDIV: begin
                if (div_rsp.done) begin
                    n_state = (r_k == TERM_W'(SERIES_TERMS)) ? S_TEND : S_TMUL;
                end
            end
            S_TEND: begin
                n_state = r_cos ? S_SQ : S_TMUL;
            end
            S_SQ: begin
                mul_a   = sn_abs[31:0];
                mul_b   = sn_abs[31:0];
                n_state = S_LMUL;
            end
            S_LMUL: begin
                mul_a   = r_prod[59:28];
                mul_b   = cs_abs[31:0];
                n_state = S_LFIN;
            end
            S_LFIN: begin
                n_state = S_TAP;
            end
            S_NSTART: begin
                if (r_i >= r_ks) begin
                    n_state = S_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.steps    = NORM_STEPS;
                    div_req.rem0     = '0;
                    div_req.dividend = {raw_abs[31:0], 16'b0};
                    div_req.divisor  = r_sum[DSR_W-1:0];
                    n_state = S_NDIV;
                end
            end
            S_NDIV: begin
                if (div_rsp.done) begin
                    n_state = S_OSTART;
                end
            end
            S_OSTART: begin
                div_req.start    = 1'b1;
                div_req.steps    = OFF_STEPS;
                div_req.rem0     = '0;
                div_req.dividend = {r_i, {(Q_W - CNT_W){1'b0}}};
                div_req.divisor  = DSR_W'(len_eff);
                n_state = S_ODIV;
            end
            S_ODIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = (r_i == CNT_W'(TAP_SLOTS - 1)) ? S_IDLE : S_NSTART;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {32'b0, mul_a} * {32'b0, mul_b};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_ratio  <= i_scale_ratio;
                    r_len    <= i_tex_length;
                    r_vert   <= i_vertical;
                    r_ks     <= calc_kernel_size(i_scale_ratio);
                    r_i      <= CNT_W'(1);
                    r_raw[0] <= RAW_W'(ONE_Q28);
                    r_sum    <= SUM_W'(ONE_Q28);
                end
            end
            S_TAP: begin
                if (r_i == CNT_W'(TAP_SLOTS)) begin
                    r_i <= '0;
                    if (r_sum <= 0) begin
                        r_sum <= SUM_W'(ONE_Q28);
                    end
                end else if (tap_skip) begin
                    r_raw[r_i[IDX_W-1:0]] <= '0;
                    r_i <= r_i + CNT_W'(1);
                end
            end
            S_UDIV: begin
                if (div_rsp.done) begin
                    r_u <= quo[27:0];
                end
            end
            S_TSTART: begin
                r_v2  <= r_prod[59:28];
                r_cos <= 1'b0;
                r_mag <= ONE_Q28;
                r_acc <= ACC_W'(ONE_Q28);
                r_k   <= TERM_W'(1);
            end
            S_TDIV: begin
                if (div_rsp.done) begin
                    r_mag <= term;
                    r_acc <= acc_next;
                    r_k   <= r_k + TERM_W'(1);
                end
            end
            S_TEND: begin
                if (r_cos) begin
                    r_cs <= r_acc;
                end else begin
                    r_sn  <= r_acc;
                    r_cos <= 1'b1;
                    r_mag <= ONE_Q28;
                    r_acc <= ACC_W'(ONE_Q28);
                    r_k   <= TERM_W'(1);
                end
            end
            S_LFIN: begin
                r_raw[r_i[IDX_W-1:0]] <= raw_new;
                r_sum <= r_sum + (SUM_W'(raw_new) <<< 1);
                r_i   <= r_i + CNT_W'(1);
            end
            S_NSTART: begin
                r_tap    <= TAPO_W'(r_i);
                r_ks_out <= TAPO_W'(r_ks);
                r_last   <= (r_i == CNT_W'(TAP_SLOTS - 1));
                if (r_i >= r_ks) begin
                    r_weight <= '0;
                    r_off_x  <= '0;
                    r_off_y  <= '0;
                end
            end
            S_NDIV: begin
                if (div_rsp.done) begin
                    r_weight <= w_new;
                end
            end
            S_ODIV: begin
                if (div_rsp.done) begin
                    r_off_x <= r_vert ? '0 : off_new;
                    r_off_y <= r_vert ? off_new : '0;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    r_i <= r_i + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_tap_index   = r_tap;
    assign o_weight      = r_weight;
    assign o_offset_x    = r_off_x;
    assign o_offset_y    = r_off_y;
    assign o_kernel_size = r_ks_out;
    assign o_last_tap    = r_last;

endmodule
